// ===== design/tcgr_pkg.sv =====
// Package for the text cell glyph renderer: shared types, register codes,
// pixel format, result struct and the fixed 16-entry VGA palette.
// No dependencies.
package tcgr_pkg;

  // Widths of the configuration port.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  // Hard cap on the number of rows a cell emits.
  localparam int unsigned MaxRowsOut = 16;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_PITCH      = 4'd0,
    REG_BYTES_PER_PIXEL = 4'd1,
    REG_RED_SIZE        = 4'd2,
    REG_GREEN_SIZE      = 4'd3,
    REG_BLUE_SIZE       = 4'd4,
    REG_RED_SHIFT       = 4'd5,
    REG_GREEN_SHIFT     = 4'd6,
    REG_BLUE_SHIFT      = 4'd7
  } cfg_reg_e;

  // Top level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PACK_FG,
    ST_PACK_BG,
    ST_LAUNCH,
    ST_RUN
  } tcgr_state_e;

  // Packed pixel format registers.
  typedef struct packed {
    logic [3:0] red_size;
    logic [3:0] green_size;
    logic [3:0] blue_size;
    logic [4:0] red_shift;
    logic [4:0] green_shift;
    logic [4:0] blue_shift;
    logic [2:0] bytes_per_pixel;
  } pix_fmt_t;

  // Per-cell job handed from the setup logic to the row engine.
  typedef struct packed {
    logic [31:0] base_address;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic        char_ok;
  } cell_job_t;

  // One row result.
  typedef struct packed {
    logic [31:0]      byte_address;
    logic [3:0]       glyph_row;
    logic [7:0][31:0] pixel;
    logic             last;
  } row_res_t;

  // VGA palette as {red, green, blue}.
  function automatic logic [23:0] vga_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000AA;
      4'd2:    rgb = 24'h00AA00;
      4'd3:    rgb = 24'h00AAAA;
      4'd4:    rgb = 24'hAA0000;
      4'd5:    rgb = 24'hAA00AA;
      4'd6:    rgb = 24'hAA5500;
      4'd7:    rgb = 24'hAAAAAA;
      4'd8:    rgb = 24'h555555;
      4'd9:    rgb = 24'h5555FF;
      4'd10:   rgb = 24'h55FF55;
      4'd11:   rgb = 24'h55FFFF;
      4'd12:   rgb = 24'hFF5555;
      4'd13:   rgb = 24'hFF55FF;
      4'd14:   rgb = 24'hFFFF55;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

endpackage

// ===== design/tcgr_if.sv =====
// Channel interfaces of the text cell glyph renderer: draw/font requests,
// row results and configuration writes. Depends on tcgr_pkg.
interface tcgr_req_if import tcgr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  char_code;
  logic [7:0]  attribute;
  logic [7:0]  column;
  logic [6:0]  cell_row;
  logic [11:0] font_address;
  logic [7:0]  font_byte;

  modport source (
    output valid, action, char_code, attribute, column, cell_row, font_address, font_byte,
    input  ready
  );
  modport sink (
    input  valid, action, char_code, attribute, column, cell_row, font_address, font_byte,
    output ready
  );
endinterface

interface tcgr_res_if import tcgr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] byte_address;
  logic [3:0]  glyph_row;
  logic [31:0] pixel_0;
  logic [31:0] pixel_1;
  logic [31:0] pixel_2;
  logic [31:0] pixel_3;
  logic [31:0] pixel_4;
  logic [31:0] pixel_5;
  logic [31:0] pixel_6;
  logic [31:0] pixel_7;
  logic        last;

  modport source (
    output valid, byte_address, glyph_row, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7, last,
    input  ready
  );
  modport sink (
    input  valid, byte_address, glyph_row, pixel_0, pixel_1, pixel_2, pixel_3,
           pixel_4, pixel_5, pixel_6, pixel_7, last,
    output ready
  );
endinterface

interface tcgr_cfg_if import tcgr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/text_cell_glyph_renderer_unit.sv =====
// Text cell glyph renderer. A font write is stored and emits nothing. A draw
// passes the shared color packer (foreground, then background) and a launch
// state, then yields one glyph row per cycle through the font RAM port while
// the result channel does not hold off. Each row passes the font RAM read
// register and the output register. Reset clears control state and loads
// default config; the font RAM is not cleared.
module text_cell_glyph_renderer_unit import tcgr_pkg::*; #(
  parameter int GLYPH_ROWS = 16,
  parameter int FONT_CHARS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcgr_req_if.sink   req_i,
  tcgr_res_if.source res_o,
  tcgr_cfg_if.sink   cfg_i
);

  localparam int StoreDepth = FONT_CHARS * GLYPH_ROWS;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int LineW      = 7 + ((GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 0);
  localparam int ProdW      = 16 + LineW;

  tcgr_state_e      state_q, state_d;
  logic [15:0]      line_pitch_q;
  pix_fmt_t         fmt_q;
  logic [7:0]       char_q;
  logic [7:0]       attr_q;
  logic [7:0]       col_q;
  logic [6:0]       crow_q;
  logic [ProdW-1:0] prod_q;
  cell_job_t        job_q;
  logic [AddrW-1:0] char_base_q;
  logic             req_fire;
  logic             launch;
  logic             font_we;
  logic [3:0]       pack_idx;
  logic [31:0]      pack_color;
  logic [2:0]       eff_bpp;
  logic [13:0]      col_bytes;
  logic [LineW-1:0] crow_lines;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             done;
  logic             res_valid;
  row_res_t         res;

  assign req_fire = req_i.valid && req_i.ready;

  // Sequencer: state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: next state and control outputs.
  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    launch      = 1'b0;
    pack_idx    = attr_q[3:0];
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid && !req_i.action) begin
          state_d = ST_PACK_FG;
        end
      end
      ST_PACK_FG: begin
        state_d = ST_PACK_BG;
      end
      ST_PACK_BG: begin
        pack_idx = attr_q[7:4];
        state_d  = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        launch  = 1'b1;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pitch_q          <= 16'd0;
      fmt_q.bytes_per_pixel <= 3'd4;
      fmt_q.red_size        <= 4'd8;
      fmt_q.green_size      <= 4'd8;
      fmt_q.blue_size       <= 4'd8;
      fmt_q.red_shift       <= 5'd16;
      fmt_q.green_shift     <= 5'd8;
      fmt_q.blue_shift      <= 5'd0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_LINE_PITCH:      line_pitch_q          <= cfg_i.data;
        REG_BYTES_PER_PIXEL: fmt_q.bytes_per_pixel <= cfg_i.data[2:0];
        REG_RED_SIZE:        fmt_q.red_size        <= cfg_i.data[3:0];
        REG_GREEN_SIZE:      fmt_q.green_size      <= cfg_i.data[3:0];
        REG_BLUE_SIZE:       fmt_q.blue_size       <= cfg_i.data[3:0];
        REG_RED_SHIFT:       fmt_q.red_shift       <= cfg_i.data[4:0];
        REG_GREEN_SHIFT:     fmt_q.green_shift     <= cfg_i.data[4:0];
        REG_BLUE_SHIFT:      fmt_q.blue_shift      <= cfg_i.data[4:0];
        default: ;
      endcase
    end
  end

  // Shared color packer, used for the foreground and then the background.
  tcgr_packer u_packer (
    .idx_i   (pack_idx),
    .fmt_i   (fmt_q),
    .color_o (pack_color)
  );

  // Address terms: scan line base and column offset in bytes.
  assign eff_bpp    = (fmt_q.bytes_per_pixel > 3'd4) ? 3'd4 : fmt_q.bytes_per_pixel;
  assign col_bytes  = {3'b000, col_q, 3'b000} * {11'd0, eff_bpp};
  assign crow_lines = LineW'(crow_q * GLYPH_ROWS);

  // Cell setup registers.
  always_ff @(posedge clk_i) begin
    if (req_fire && !req_i.action) begin
      char_q <= req_i.char_code;
      attr_q <= req_i.attribute;
      col_q  <= req_i.column;
      crow_q <= req_i.cell_row;
    end
    if (state_q == ST_PACK_FG) begin
      prod_q         <= ProdW'(line_pitch_q * crow_lines);
      job_q.fg_color <= pack_color;
      job_q.char_ok  <= (32'(char_q) < 32'(FONT_CHARS));
      char_base_q    <= AddrW'(char_q * GLYPH_ROWS);
    end
    if (state_q == ST_PACK_BG) begin
      job_q.bg_color     <= pack_color;
      job_q.base_address <= 32'(prod_q) + {18'd0, col_bytes};
    end
  end

  // Font store.
  assign font_we = req_fire && req_i.action &&
                   (32'(req_i.font_address) < 32'(StoreDepth));

  tcgr_ram #(
    .Width (8),
    .Depth (StoreDepth)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (AddrW'(req_i.font_address)),
    .wdata_i (req_i.font_byte),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Row engine.
  tcgr_row_engine #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .AddrW      (AddrW)
  ) u_row_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (launch),
    .job_i        (job_q),
    .char_base_i  (char_base_q),
    .line_pitch_i (line_pitch_q),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res),
    .done_o       (done)
  );

  // Result channel.
  assign res_o.valid        = res_valid;
  assign res_o.byte_address = res.byte_address;
  assign res_o.glyph_row    = res.glyph_row;
  assign res_o.pixel_0      = res.pixel[0];
  assign res_o.pixel_1      = res.pixel[1];
  assign res_o.pixel_2      = res.pixel[2];
  assign res_o.pixel_3      = res.pixel[3];
  assign res_o.pixel_4      = res.pixel[4];
  assign res_o.pixel_5      = res.pixel[5];
  assign res_o.pixel_6      = res.pixel[6];
  assign res_o.pixel_7      = res.pixel[7];
  assign res_o.last         = res.last;

endmodule

// ===== design/tcgr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcgr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tcgr_packer.sv =====
// Color packer: looks up a VGA palette entry and packs it into the
// configured pixel format. Depends on tcgr_pkg.
module tcgr_packer import tcgr_pkg::*; (
  input  logic [3:0]  idx_i,
  input  pix_fmt_t    fmt_i,
  output logic [31:0] color_o
);

  logic [23:0] rgb;
  logic [31:0] red_part;
  logic [31:0] green_part;
  logic [31:0] blue_part;
  logic [31:0] packed_color;
  logic [2:0]  eff_bpp;

  // Mask a component to its size (capped at 8) and move it into place.
  function automatic logic [31:0] place(input logic [7:0] value, input logic [3:0] size,
                                        input logic [4:0] shift);
    logic [3:0] n;
    logic [7:0] mask;
    n    = (size > 4'd8) ? 4'd8 : size;
    mask = 8'((9'd1 << n) - 9'd1);
    return {24'd0, value & mask} << shift;
  endfunction

  assign rgb = vga_rgb(idx_i);

  always_comb begin
    red_part     = place(rgb[23:16], fmt_i.red_size, fmt_i.red_shift);
    green_part   = place(rgb[15:8], fmt_i.green_size, fmt_i.green_shift);
    blue_part    = place(rgb[7:0], fmt_i.blue_size, fmt_i.blue_shift);
    packed_color = red_part | green_part | blue_part;
  end

  // Cut the packed value to the pixel size in bytes.
  assign eff_bpp = (fmt_i.bytes_per_pixel > 3'd4) ? 3'd4 : fmt_i.bytes_per_pixel;

  always_comb begin
    case (eff_bpp)
      3'd0:    color_o = 32'd0;
      3'd1:    color_o = packed_color & 32'h0000_00FF;
      3'd2:    color_o = packed_color & 32'h0000_FFFF;
      3'd3:    color_o = packed_color & 32'h00FF_FFFF;
      default: color_o = packed_color;
    endcase
  end

endmodule

// ===== design/tcgr_row_engine.sv =====
// Row engine: issues one font read per glyph row, expands the glyph byte into
// eight pixels and steps the framebuffer address with one shared adder.
// Depends on tcgr_pkg.
module tcgr_row_engine import tcgr_pkg::*; #(
  parameter int GLYPH_ROWS = 16,
  parameter int AddrW      = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  cell_job_t        job_i,
  input  logic [AddrW-1:0] char_base_i,
  input  logic [15:0]      line_pitch_i,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [7:0]       rd_data_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output row_res_t         res_o,
  output logic             done_o
);

  localparam int NumRows = (GLYPH_ROWS > MaxRowsOut) ? MaxRowsOut : GLYPH_ROWS;
  localparam int RowW    = (NumRows > 1) ? $clog2(NumRows) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(NumRows - 1);

  logic            busy_q, busy_d;
  logic            issued_all_q, issued_all_d;
  logic [RowW-1:0] issue_row_q, issue_row_d;
  logic            fetch_valid_q, fetch_valid_d;
  logic [RowW-1:0] fetch_row_q, fetch_row_d;
  logic            out_valid_q, out_valid_d;
  row_res_t        out_q, out_d;
  logic [31:0]     acc_q, acc_d;
  logic            issue;
  logic            fetch_move;
  logic [7:0]      bits;

  // Handoff from the fetch stage into the output register.
  assign fetch_move = fetch_valid_q && (!out_valid_q || res_ready_i);
  assign issue      = busy_q && !issued_all_q && (!fetch_valid_q || fetch_move);
  assign rd_en_o    = issue;
  assign rd_addr_o  = char_base_i + AddrW'(issue_row_q);
  assign bits       = job_i.char_ok ? rd_data_i : 8'd0;
  assign done_o     = fetch_move && (fetch_row_q == LastRow);

  // Next-state logic for the row pipeline.
  always_comb begin
    busy_d        = busy_q;
    issued_all_d  = issued_all_q;
    issue_row_d   = issue_row_q;
    fetch_valid_d = fetch_valid_q;
    fetch_row_d   = fetch_row_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    acc_d         = acc_q;

    if (start_i) begin
      busy_d       = 1'b1;
      issued_all_d = 1'b0;
      issue_row_d  = '0;
      acc_d        = job_i.base_address;
    end

    if (issue) begin
      fetch_valid_d = 1'b1;
      fetch_row_d   = issue_row_q;
      if (issue_row_q == LastRow) begin
        issued_all_d = 1'b1;
      end else begin
        issue_row_d = issue_row_q + RowW'(1);
      end
    end else if (fetch_move) begin
      fetch_valid_d = 1'b0;
    end

    if (fetch_move) begin
      out_valid_d        = 1'b1;
      out_d.byte_address = acc_q;
      out_d.glyph_row    = 4'(fetch_row_q);
      out_d.last         = (fetch_row_q == LastRow);
      for (int j = 0; j < 8; j++) begin
        out_d.pixel[j] = bits[7-j] ? job_i.fg_color : job_i.bg_color;
      end
      acc_d = acc_q + {16'd0, line_pitch_i};
      if (fetch_row_q == LastRow) begin
        busy_d = 1'b0;
      end
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      issued_all_q  <= 1'b0;
      issue_row_q   <= '0;
      fetch_valid_q <= 1'b0;
      fetch_row_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      busy_q        <= busy_d;
      issued_all_q  <= issued_all_d;
      issue_row_q   <= issue_row_d;
      fetch_valid_q <= fetch_valid_d;
      fetch_row_q   <= fetch_row_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    acc_q <= acc_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ===== design/tcgr_checker.sv =====
// Port-level checker for the text cell glyph renderer and its bind.
// Depends on text_cell_glyph_renderer_unit and its interfaces.
module tcgr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       req_action_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       res_last_i,
  input logic [3:0] res_glyph_row_i
);

  // A draw request closes the input until its cell is rendered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && !req_action_i) |=> !req_ready_i)
  else $error("input ready right after a draw request");

  // A font write leaves the block ready for the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && req_action_i) |=> req_ready_i)
  else $error("font write did not return to ready");

  // No new request is taken while a row other than the last of a cell is on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_last_i) |-> !req_ready_i)
  else $error("request ready while a cell is unfinished");

  // Rows of a cell follow back to back in order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && res_ready_i && !res_last_i) |=>
      (res_valid_i && (res_glyph_row_i == $past(res_glyph_row_i) + 4'd1)))
  else $error("glyph rows out of sequence");

endmodule

bind text_cell_glyph_renderer_unit tcgr_checker u_tcgr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_action_i    (req_i.action),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_last_i      (res_o.last),
  .res_glyph_row_i (res_o.glyph_row)
);

// ===== bench/tb.sv =====
// Self-checking bench for text_cell_glyph_renderer_unit: font loads, cell draws and
// pixel-format changes, each row result checked against an in-bench model of the cell.
// Depends on tcgr_pkg and the tcgr_req_if, tcgr_res_if and tcgr_cfg_if interfaces.
module tb;
  import tcgr_pkg::*;

  localparam int GlyphRows      = 16;
  localparam int FontChars      = 256;
  localparam int StoreDepth     = GlyphRows * FontChars;
  localparam int CellRows       = (GlyphRows > MaxRowsOut) ? MaxRowsOut : GlyphRows;
  localparam int ItemsPerPhase  = 43;
  localparam int IdleSettle     = 25;
  localparam int RxHoldCycles   = 300;
  localparam int WatchdogLimit  = 4000;
  localparam int MaxReportLines = 100;

  localparam logic ActDraw      = 1'b0;
  localparam logic ActFontWrite = 1'b1;

  // An index past the last register; writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 4'hC;

  // Standard 16-color text palette as {red, green, blue}, entry 15 first.
  localparam logic [15:0][23:0] VgaColors = {
    24'hFFFFFF, 24'hFFFF55, 24'hFF55FF, 24'hFF5555,
    24'h55FFFF, 24'h55FF55, 24'h5555FF, 24'h555555,
    24'hAAAAAA, 24'hAA5500, 24'hAA00AA, 24'hAA0000,
    24'h00AAAA, 24'h00AA00, 24'h0000AA, 24'h000000
  };

  typedef struct packed {
    logic        action;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [7:0]  column;
    logic [6:0]  cell_row;
    logic [11:0] font_address;
    logic [7:0]  font_byte;
  } cell_req_t;

  typedef struct packed {
    cell_req_t   rq;
    logic        has_exp;
    logic [31:0] addr0;
    logic [31:0] fg;
    logic [31:0] bg;
  } dir_entry_t;

  typedef struct packed {
    logic [15:0] pitch;
    pix_fmt_t    fmt;
  } fmt_phase_t;

  logic clk_i;
  logic rst_ni;

  tcgr_req_if req_bus ();
  tcgr_res_if res_bus ();
  tcgr_cfg_if cfg_bus ();

  text_cell_glyph_renderer_unit #(
    .GLYPH_ROWS (GlyphRows),
    .FONT_CHARS (FontChars)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // Bench copy of the font, the pixel format and the rows still owed by the block.
  logic [7:0] glyph_mem [StoreDepth];
  bit         glyph_set [StoreDepth];
  bit         char_drawable [FontChars];
  logic [7:0] drawable_chars [$];
  logic [15:0] pitch_sh;
  pix_fmt_t    fmt_sh;
  row_res_t    pending_rows [$];

  int mismatches;
  int rows_checked;
  int cells_drawn;
  int font_bytes;
  int req_count;
  int formats_run;
  int stuck_cycles;
  bit tx_calm;
  bit rx_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < MaxReportLines) begin
      $display("mismatch on %s: got %h, want %h", field, got, want);
    end
    mismatches++;
  endtask

  // Color and address arithmetic of the cell renderer.
  function automatic logic [2:0] eff_bpp();
    return (fmt_sh.bytes_per_pixel > 3'd4) ? 3'd4 : fmt_sh.bytes_per_pixel;
  endfunction

  function automatic logic [31:0] place_comp(input logic [7:0] level, input logic [3:0] width,
                                             input logic [4:0] pos);
    logic [3:0]  n;
    logic [7:0]  keep;
    logic [31:0] wide;
    n    = (width > 4'd8) ? 4'd8 : width;
    keep = 8'((9'd1 << n) - 9'd1);
    wide = {24'd0, level & keep};
    return wide << pos;
  endfunction

  function automatic logic [31:0] pack_color(input logic [3:0] idx);
    logic [23:0] rgb;
    logic [31:0] packed_rgb;
    rgb = VgaColors[idx];
    packed_rgb = place_comp(rgb[23:16], fmt_sh.red_size, fmt_sh.red_shift)
               | place_comp(rgb[15:8], fmt_sh.green_size, fmt_sh.green_shift)
               | place_comp(rgb[7:0], fmt_sh.blue_size, fmt_sh.blue_shift);
    // Narrow pixels keep only their low bytes; zero width keeps nothing.
    if (eff_bpp() >= 3'd4) return packed_rgb;
    return packed_rgb & ~(32'hFFFF_FFFF << (8 * eff_bpp()));
  endfunction

  function automatic logic [31:0] row_address(input logic [7:0] col, input logic [6:0] crow,
                                              input int r);
    logic [31:0] line;
    line = 32'(crow) * 32'(GlyphRows) + 32'(r);
    return 32'(pitch_sh) * line + 32'(col) * 32'd8 * 32'(eff_bpp());
  endfunction

  // Queue the rows that one draw request produces.
  function automatic void render_cell_rows(input cell_req_t rq);
    logic [31:0] fg;
    logic [31:0] bg;
    logic [7:0]  bits;
    row_res_t    row;
    fg = pack_color(rq.attribute[3:0]);
    bg = pack_color(rq.attribute[7:4]);
    for (int r = 0; r < CellRows; r++) begin
      bits = (rq.char_code < FontChars) ? glyph_mem[int'(rq.char_code) * GlyphRows + r] : 8'd0;
      row.byte_address = row_address(rq.column, rq.cell_row, r);
      row.glyph_row    = 4'(r);
      for (int j = 0; j < 8; j++) begin
        row.pixel[j] = bits[7 - j] ? fg : bg;
      end
      row.last = (r == CellRows - 1);
      pending_rows.push_back(row);
    end
  endfunction

  // Font store update; a character becomes drawable once all its rows are written.
  function automatic void store_font_byte(input logic [11:0] addr, input logic [7:0] value);
    int ch;
    bit whole;
    if (addr < StoreDepth) begin
      glyph_mem[addr] = value;
      glyph_set[addr] = 1'b1;
      ch = int'(addr) / GlyphRows;
      if (!char_drawable[ch]) begin
        whole = 1'b1;
        for (int r = 0; r < GlyphRows; r++) whole &= glyph_set[ch * GlyphRows + r];
        if (whole) begin
          char_drawable[ch] = 1'b1;
          drawable_chars.push_back(8'(ch));
        end
      end
    end
  endfunction

  function automatic void apply_cfg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    case (cfg_reg_e'(idx))
      REG_LINE_PITCH:      pitch_sh = value;
      REG_BYTES_PER_PIXEL: fmt_sh.bytes_per_pixel = value[2:0];
      REG_RED_SIZE:        fmt_sh.red_size = value[3:0];
      REG_GREEN_SIZE:      fmt_sh.green_size = value[3:0];
      REG_BLUE_SIZE:       fmt_sh.blue_size = value[3:0];
      REG_RED_SHIFT:       fmt_sh.red_shift = value[4:0];
      REG_GREEN_SHIFT:     fmt_sh.green_shift = value[4:0];
      REG_BLUE_SHIFT:      fmt_sh.blue_shift = value[4:0];
      default: ;
    endcase
  endfunction

  // Request builders; fields the action ignores still carry random values.
  function automatic cell_req_t mk_draw(input logic [7:0] ch, input logic [7:0] attr,
                                        input logic [7:0] col, input logic [6:0] crow);
    cell_req_t rq;
    rq.action       = ActDraw;
    rq.char_code    = ch;
    rq.attribute    = attr;
    rq.column       = col;
    rq.cell_row     = crow;
    rq.font_address = 12'($urandom);
    rq.font_byte    = 8'($urandom);
    return rq;
  endfunction

  function automatic cell_req_t mk_font(input logic [11:0] addr, input logic [7:0] value);
    cell_req_t rq;
    rq.action       = ActFontWrite;
    rq.char_code    = 8'($urandom);
    rq.attribute    = 8'($urandom);
    rq.column       = 8'($urandom);
    rq.cell_row     = 7'($urandom);
    rq.font_address = addr;
    rq.font_byte    = value;
    return rq;
  endfunction

  function automatic dir_entry_t mk_dir(input cell_req_t rq, input logic has_exp,
                                        input logic [31:0] addr0, input logic [31:0] fg,
                                        input logic [31:0] bg);
    dir_entry_t e;
    e.rq      = rq;
    e.has_exp = has_exp;
    e.addr0   = addr0;
    e.fg      = fg;
    e.bg      = bg;
    return e;
  endfunction

  function automatic fmt_phase_t mk_fmt(input logic [15:0] pitch, input logic [2:0] bpp,
                                        input logic [3:0] rsz, input logic [3:0] gsz,
                                        input logic [3:0] bsz, input logic [4:0] rsh,
                                        input logic [4:0] gsh, input logic [4:0] bsh);
    fmt_phase_t f;
    f.pitch                = pitch;
    f.fmt.bytes_per_pixel  = bpp;
    f.fmt.red_size         = rsz;
    f.fmt.green_size       = gsz;
    f.fmt.blue_size        = bsz;
    f.fmt.red_shift        = rsh;
    f.fmt.green_shift      = gsh;
    f.fmt.blue_shift       = bsh;
    return f;
  endfunction

  // Sender gaps: mostly none or short, a few long, none during calm stretches.
  function automatic int tx_gap();
    int roll;
    if (tx_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request, hold it until taken, then predict its effect.
  task automatic push_req(input cell_req_t rq);
    int gap;
    req_bus.valid        <= 1'b1;
    req_bus.action       <= rq.action;
    req_bus.char_code    <= rq.char_code;
    req_bus.attribute    <= rq.attribute;
    req_bus.column       <= rq.column;
    req_bus.cell_row     <= rq.cell_row;
    req_bus.font_address <= rq.font_address;
    req_bus.font_byte    <= rq.font_byte;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    req_count++;
    if (rq.action == ActFontWrite) begin
      store_font_byte(rq.font_address, rq.font_byte);
      font_bytes++;
    end else begin
      render_cell_rows(rq);
      cells_drawn++;
    end
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_rows_drained();
    while (pending_rows.size() != 0) @(posedge clk_i);
  endtask

  // Stop offering, let every owed row arrive, then let a trailing font write settle.
  task automatic quiesce();
    req_bus.valid <= 1'b0;
    wait_rows_drained();
    repeat (IdleSettle) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    apply_cfg(idx, value);
  endtask

  task automatic program_format(input fmt_phase_t f, input bit with_spare);
    write_cfg(REG_LINE_PITCH, f.pitch);
    write_cfg(REG_BYTES_PER_PIXEL, 16'(f.fmt.bytes_per_pixel));
    write_cfg(REG_RED_SIZE, 16'(f.fmt.red_size));
    write_cfg(REG_GREEN_SIZE, 16'(f.fmt.green_size));
    write_cfg(REG_BLUE_SIZE, 16'(f.fmt.blue_size));
    write_cfg(REG_RED_SHIFT, 16'(f.fmt.red_shift));
    write_cfg(REG_GREEN_SHIFT, 16'(f.fmt.green_shift));
    write_cfg(REG_BLUE_SHIFT, 16'(f.fmt.blue_shift));
    if (with_spare) write_cfg(CfgIdxSpare, 16'($urandom));
    cfg_bus.valid <= 1'b0;
    formats_run++;
  endtask

  // Random traffic of one phase: mostly draws of loaded glyphs, with glyph loads,
  // stray font writes, broken glyph loads and cells at the screen corners.
  task automatic run_random_items(input int phase_no);
    int start;
    int pick;
    int span;
    int first;
    bit pressed;
    logic [7:0] ch;
    start   = req_count;
    pressed = 1'b0;
    while (req_count - start < ItemsPerPhase) begin
      if (!pressed && req_count - start >= 10) begin
        pressed = 1'b1;
        if (phase_no == 2) rx_hold_req = 1'b1;
        if (phase_no == 3) begin
          req_bus.valid <= 1'b0;
          wait_rows_drained();
          @(posedge clk_i);
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        ch = drawable_chars[$urandom_range(0, drawable_chars.size() - 1)];
        push_req(mk_draw(ch, 8'($urandom), 8'($urandom), 7'($urandom)));
      end else if (pick < 72) begin
        push_req(mk_font(12'($urandom), 8'($urandom)));
      end else if (pick < 77) begin
        ch = 8'($urandom);
        for (int r = 0; r < GlyphRows; r++) begin
          push_req(mk_font(12'(int'(ch) * GlyphRows + r), 8'($urandom)));
        end
      end else if (pick < 82) begin
        ch    = 8'($urandom);
        span  = $urandom_range(1, GlyphRows - 1);
        first = $urandom_range(0, GlyphRows - 1);
        for (int k = 0; k < span; k++) begin
          push_req(mk_font(12'(int'(ch) * GlyphRows + (first + k) % GlyphRows), 8'($urandom)));
        end
      end else begin
        ch = drawable_chars[$urandom_range(0, drawable_chars.size() - 1)];
        push_req(mk_draw(ch, 8'($urandom), $urandom_range(0, 1) ? 8'hFF : 8'h00,
                         $urandom_range(0, 1) ? 7'h7F : 7'h00));
      end
    end
  endtask

  // Result side: compare each accepted row with the oldest owed row.
  always @(posedge clk_i) begin : row_check
    row_res_t got;
    row_res_t want;
    if (rst_ni === 1'b1 && res_bus.valid && res_bus.ready) begin
      got.byte_address = res_bus.byte_address;
      got.glyph_row    = res_bus.glyph_row;
      got.pixel        = {res_bus.pixel_7, res_bus.pixel_6, res_bus.pixel_5, res_bus.pixel_4,
                          res_bus.pixel_3, res_bus.pixel_2, res_bus.pixel_1, res_bus.pixel_0};
      got.last         = res_bus.last;
      if (pending_rows.size() == 0) begin
        flag_mismatch("unexpected row address", got.byte_address, 32'd0);
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (got.byte_address !== want.byte_address)
          flag_mismatch("byte_address", got.byte_address, want.byte_address);
        if (got.glyph_row !== want.glyph_row)
          flag_mismatch("glyph_row", 32'(got.glyph_row), 32'(want.glyph_row));
        for (int j = 0; j < 8; j++) begin
          if (got.pixel[j] !== want.pixel[j])
            flag_mismatch($sformatf("pixel_%0d of row %0d", j, want.glyph_row),
                          got.pixel[j], want.pixel[j]);
        end
        if (got.last !== want.last)
          flag_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d rows owed",
               stuck_cycles, pending_rows.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver back-pressure: calm runs, random short and long stalls, and one long
  // hold-off on request from the stimulus side.
  initial begin : rx_side
    int run_len;
    int roll;
    bit calm;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
      end else begin
        run_len = $urandom_range(10, 60);
        calm    = ($urandom_range(0, 3) == 0);
        repeat (run_len) begin
          roll = $urandom_range(0, 99);
          if (calm || roll < 70) begin
            res_bus.ready <= 1'b1;
            @(posedge clk_i);
          end else if (roll < 96) begin
            res_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk_i);
          end else begin
            res_bus.ready <= 1'b0;
            repeat ($urandom_range(15, 50)) @(posedge clk_i);
          end
        end
      end
    end
  end

  // Stimulus: reset, font setup, directed cells, then random phases over many formats.
  initial begin : stim
    dir_entry_t dir_rows [$];
    fmt_phase_t formats [$];
    fmt_phase_t f;

    rst_ni               <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.action       <= ActDraw;
    req_bus.char_code    <= 8'd0;
    req_bus.attribute    <= 8'd0;
    req_bus.column       <= 8'd0;
    req_bus.cell_row     <= 7'd0;
    req_bus.font_address <= 12'd0;
    req_bus.font_byte    <= 8'd0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= REG_LINE_PITCH;
    cfg_bus.data         <= 16'd0;

    // Register values after reset.
    pitch_sh               = 16'd0;
    fmt_sh.bytes_per_pixel = 3'd4;
    fmt_sh.red_size        = 4'd8;
    fmt_sh.green_size      = 4'd8;
    fmt_sh.blue_size       = 4'd8;
    fmt_sh.red_shift       = 5'd16;
    fmt_sh.green_shift     = 5'd8;
    fmt_sh.blue_shift      = 5'd0;
    formats_run            = 1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Glyphs used by the directed cells: blank, solid and a mixed pattern.
    for (int r = 0; r < GlyphRows; r++) push_req(mk_font(12'(r), 8'h00));
    for (int r = 0; r < GlyphRows; r++) push_req(mk_font(12'(255 * GlyphRows + r), 8'hFF));
    for (int r = 0; r < GlyphRows; r++)
      push_req(mk_font(12'(8'h5A * GlyphRows + r), 8'hA5 ^ 8'(r * 17)));

    // Directed cells under the reset format (pitch 0, four bytes, 8:8:8 at 16/8/0).
    dir_rows.push_back(mk_dir(mk_draw(8'hFF, 8'h1E, 8'hFF, 7'h7F), 1'b1,
                              32'h1FE0, 32'h00FF_FF55, 32'h0000_00AA));
    dir_rows.push_back(mk_dir(mk_draw(8'h00, 8'hF0, 8'h00, 7'h00), 1'b1,
                              32'h0000, 32'h0000_0000, 32'h00FF_FFFF));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'h00, 8'h01, 7'h01), 1'b1,
                              32'h0020, 32'h0000_0000, 32'h0000_0000));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'hFF, 8'h80, 7'h40), 1'b1,
                              32'h1000, 32'h00FF_FFFF, 32'h00FF_FFFF));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'h32, 8'h02, 7'h03), 1'b1,
                              32'h0040, 32'h0000_AA00, 32'h0000_AAAA));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'h54, 8'h03, 7'h03), 1'b1,
                              32'h0060, 32'h00AA_0000, 32'h00AA_00AA));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'h76, 8'h04, 7'h03), 1'b1,
                              32'h0080, 32'h00AA_5500, 32'h00AA_AAAA));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'h98, 8'h05, 7'h03), 1'b1,
                              32'h00A0, 32'h0055_5555, 32'h0055_55FF));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'hBA, 8'h06, 7'h03), 1'b1,
                              32'h00C0, 32'h0055_FF55, 32'h0055_FFFF));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'hDC, 8'h07, 7'h03), 1'b1,
                              32'h00E0, 32'h00FF_5555, 32'h00FF_55FF));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'hEF, 8'h08, 7'h03), 1'b1,
                              32'h0100, 32'h00FF_FFFF, 32'h00FF_FF55));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'h01, 8'h09, 7'h03), 1'b1,
                              32'h0120, 32'h0000_00AA, 32'h0000_0000));
    // Font writes at both ends of the store and in the middle, then cells that use them.
    dir_rows.push_back(mk_dir(mk_font(12'h000, 8'h81), 1'b0, 32'd0, 32'd0, 32'd0));
    dir_rows.push_back(mk_dir(mk_font(12'hFFF, 8'h00), 1'b0, 32'd0, 32'd0, 32'd0));
    dir_rows.push_back(mk_dir(mk_font(12'h5A7, 8'hFF), 1'b0, 32'd0, 32'd0, 32'd0));
    dir_rows.push_back(mk_dir(mk_draw(8'h00, 8'h4A, 8'h0A, 7'h05), 1'b0, 32'd0, 32'd0, 32'd0));
    dir_rows.push_back(mk_dir(mk_draw(8'hFF, 8'hC3, 8'hC8, 7'h64), 1'b0, 32'd0, 32'd0, 32'd0));
    dir_rows.push_back(mk_dir(mk_draw(8'h5A, 8'h2D, 8'h55, 7'h2A), 1'b0, 32'd0, 32'd0, 32'd0));

    foreach (dir_rows[i]) begin
      push_req(dir_rows[i].rq);
      if (dir_rows[i].has_exp) begin
        if (row_address(dir_rows[i].rq.column, dir_rows[i].rq.cell_row, 0) !== dir_rows[i].addr0)
          flag_mismatch("directed row 0 address",
                        row_address(dir_rows[i].rq.column, dir_rows[i].rq.cell_row, 0),
                        dir_rows[i].addr0);
        if (pack_color(dir_rows[i].rq.attribute[3:0]) !== dir_rows[i].fg)
          flag_mismatch("directed foreground", pack_color(dir_rows[i].rq.attribute[3:0]),
                        dir_rows[i].fg);
        if (pack_color(dir_rows[i].rq.attribute[7:4]) !== dir_rows[i].bg)
          flag_mismatch("directed background", pack_color(dir_rows[i].rq.attribute[7:4]),
                        dir_rows[i].bg);
      end
    end

    run_random_items(0);

    // Fixed formats: widest pitch, RGB565, RGB332, oversize and clipped fields,
    // zero-byte pixels and oversize byte width; then fully random formats.
    formats.push_back(mk_fmt(16'hFFFF, 3'd4, 4'd8, 4'd8, 4'd8, 5'd24, 5'd16, 5'd8));
    formats.push_back(mk_fmt(16'd1280, 3'd2, 4'd5, 4'd6, 4'd5, 5'd11, 5'd5, 5'd0));
    formats.push_back(mk_fmt(16'd320, 3'd1, 4'd3, 4'd3, 4'd2, 5'd5, 5'd2, 5'd0));
    formats.push_back(mk_fmt(16'h8001, 3'd3, 4'd15, 4'd9, 4'd0, 5'd31, 5'd30, 5'd29));
    formats.push_back(mk_fmt(16'd1, 3'd0, 4'd8, 4'd8, 4'd8, 5'd0, 5'd8, 5'd16));
    formats.push_back(mk_fmt(16'd12345, 3'd7, 4'd4, 4'd4, 4'd4, 5'd0, 5'd0, 5'd0));

    for (int p = 1; p <= 8; p++) begin
      if (p <= formats.size()) begin
        f = formats[p - 1];
      end else begin
        f = mk_fmt(16'($urandom), 3'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                   5'($urandom), 5'($urandom), 5'($urandom));
      end
      quiesce();
      program_format(f, p == 6);
      run_random_items(p);
    end

    req_bus.valid <= 1'b0;
    wait_rows_drained();
    repeat (IdleSettle) @(posedge clk_i);

    $display("summary: %0d requests (%0d cells drawn, %0d font bytes), %0d rows checked",
             req_count, cells_drawn, font_bytes, rows_checked);
    $display("summary: %0d pixel formats, byte widths 0 to 7, sizes 0 to 15, shifts 0 to 31",
             formats_run);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tcgr_pkg.sv
design/tcgr_if.sv
design/tcgr_ram.sv
design/tcgr_packer.sv
design/tcgr_row_engine.sv
design/text_cell_glyph_renderer_unit.sv
design/tcgr_checker.sv
bench/tb.sv
